// File: rtl/tcu_pkg.sv
// shared constants and types for the tick counter uptime unit
package tcu_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int WRAP_W     = 32;
  localparam int RATE_W     = 20;
  localparam int MS_W       = 64;
  localparam int FRAC_W     = 10;
  localparam int FR_W       = RATE_W + FRAC_W;
  localparam int DVS_W      = RATE_W + FRAC_W - 1;
  localparam int TICK_WIDTH_DFLT = 32;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);
  localparam logic [FRAC_W-1:0] MS_PER_SEC = FRAC_W'(1000);

  // 1000 = 1024 - 16 - 8
  localparam int MS_SH_HI  = 10;
  localparam int MS_SH_MID = 4;
  localparam int MS_SH_LO  = 3;

  // largest whole-second count whose product with 1000 still fits
  localparam logic [MS_W-1:0] WHOLE_LIMIT = 64'd18446744073709551;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_FRAC,
    ST_SUM
  } tcu_state_t;

endpackage

// File: rtl/tcu_if.sv
// valid/ready channel interfaces for samples and uptime results
interface tcu_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcu_pkg::SAMPLE_W-1:0]  tick_sample;

  modport source(output valid, output tick_sample, input ready);
  modport sink(input valid, input tick_sample, output ready);
endinterface

interface tcu_out_if;
  logic                      valid;
  logic                      ready;
  logic [tcu_pkg::MS_W-1:0]  uptime_ms;
  logic                      saturated;

  modport source(output valid, output uptime_ms, output saturated, input ready);
  modport sink(input valid, input uptime_ms, input saturated, output ready);
endinterface

// File: rtl/tick_counter_uptime_ms_unit.sv
// tick counter extension to 64 bits and conversion to uptime in milliseconds
//
// in_ch carries one sample of a free-running tick counter per item; only its
// low TICK_WIDTH bits count. a sample lower than the one before counts a wrap,
// and the wrap count above the sample bits forms the tick total.
// out_ch returns one item per sample: the total converted to milliseconds at
// the rate held in the cfg register (cfg_we/cfg_wdata, ticks per second, zero
// read as one), clamped to all ones with saturated set when it does not fit.
// the division runs one quotient bit per cycle through a shift register,
// then the sub-second fraction takes 10 more restoring steps, one
// millisecond digit bit each.
// in_ch.ready is high only in the idle state, so a new sample is taken
// only once the one before has passed the division, the fraction and the
// sum into the output register.
// the output register decouples the sides: a new sample is accepted while an
// unread result waits; if out_ch is still stalled when the next result is
// done, the unit holds that result until the register frees up.
// reset: rate goes to 1000 ticks per second, wrap count and last sample clear,
// no result is pending.
module tick_counter_uptime_ms_unit #(
  parameter int TICK_WIDTH = tcu_pkg::TICK_WIDTH_DFLT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tcu_pkg::RATE_W-1:0]  cfg_wdata,
  tcu_in_if.sink                      in_ch,
  tcu_out_if.source                   out_ch
);

  // tick total width: wrap count above the sample bits
  localparam int TOT_W = tcu_pkg::WRAP_W + TICK_WIDTH;
  localparam int CNT_W = $clog2(TOT_W);

  // control state
  tcu_pkg::tcu_state_t               state_r, state_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic [tcu_pkg::RATE_W-1:0]        rate_r, rate_nxt;
  logic [tcu_pkg::WRAP_W-1:0]        wrap_r, wrap_nxt;
  logic [TICK_WIDTH-1:0]             last_r, last_nxt;
  logic                              out_vld_r, out_vld_nxt;

  // datapath
  logic [tcu_pkg::RATE_W-1:0]        div_rate_r, div_rate_nxt;
  logic [TOT_W-1:0]                  quo_r, quo_nxt;
  logic [tcu_pkg::RATE_W-1:0]        rem_r, rem_nxt;
  logic [tcu_pkg::FR_W-1:0]          fr_r, fr_nxt;
  logic [tcu_pkg::DVS_W-1:0]         dvs_r, dvs_nxt;
  logic [tcu_pkg::FRAC_W-1:0]        frac_r, frac_nxt;
  logic [tcu_pkg::MS_W-1:0]          base_r, base_nxt;
  logic                              sat_r, sat_nxt;
  logic [tcu_pkg::MS_W-1:0]          out_ms_r, out_ms_nxt;
  logic                              out_sat_r, out_sat_nxt;

  logic                              accept;
  logic [TICK_WIDTH-1:0]             cur_sample;
  logic                              wrap_inc;
  logic [tcu_pkg::RATE_W:0]          rem_sh;
  logic [tcu_pkg::RATE_W:0]          rem_dif;
  logic                              div_ge;
  logic                              frac_ge;
  logic [tcu_pkg::MS_W-1:0]          whole;
  logic [tcu_pkg::MS_W:0]            ms_sum;
  logic                              sum_sat;

  assign in_ch.ready      = (state_r == tcu_pkg::ST_IDLE);
  assign accept           = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_vld_r;
  assign out_ch.uptime_ms = out_ms_r;
  assign out_ch.saturated = out_sat_r;

  assign cur_sample = in_ch.tick_sample[TICK_WIDTH-1:0];
  assign wrap_inc   = (cur_sample < last_r);

  // one restoring step of the tick division: next dividend bit into remainder
  assign rem_sh  = {rem_r, quo_r[TOT_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, div_rate_r});
  assign rem_dif = rem_sh - {1'b0, div_rate_r};

  // one restoring step of the millisecond fraction
  assign frac_ge = (fr_r >= {1'b0, dvs_r});

  assign whole   = tcu_pkg::MS_W'(quo_r);
  assign ms_sum  = {1'b0, base_r} + (tcu_pkg::MS_W + 1)'(frac_r);
  assign sum_sat = sat_r || ms_sum[tcu_pkg::MS_W];

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    rate_nxt     = cfg_we ? cfg_wdata : rate_r;
    wrap_nxt     = wrap_r;
    last_nxt     = last_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    div_rate_nxt = div_rate_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    fr_nxt       = fr_r;
    dvs_nxt      = dvs_r;
    frac_nxt     = frac_r;
    base_nxt     = base_r;
    sat_nxt      = sat_r;
    out_ms_nxt   = out_ms_r;
    out_sat_nxt  = out_sat_r;

    unique case (state_r)
      tcu_pkg::ST_IDLE: begin
        if (accept) begin
          wrap_nxt     = wrap_r + tcu_pkg::WRAP_W'(wrap_inc);
          last_nxt     = cur_sample;
          quo_nxt      = {wrap_nxt, cur_sample};
          rem_nxt      = '0;
          div_rate_nxt = (rate_r == '0) ? tcu_pkg::RATE_W'(1) : rate_r;
          cnt_nxt      = CNT_W'(TOT_W - 1);
          state_nxt    = tcu_pkg::ST_DIV;
        end
      end
      tcu_pkg::ST_DIV: begin
        rem_nxt = div_ge ? rem_dif[tcu_pkg::RATE_W-1:0] : rem_sh[tcu_pkg::RATE_W-1:0];
        quo_nxt = {quo_r[TOT_W-2:0], div_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = tcu_pkg::ST_PREP;
        end
      end
      tcu_pkg::ST_PREP: begin
        // quo_r now holds whole seconds, rem_r the leftover ticks
        fr_nxt   = tcu_pkg::FR_W'(rem_r) * tcu_pkg::FR_W'(tcu_pkg::MS_PER_SEC);
        dvs_nxt  = tcu_pkg::DVS_W'(div_rate_r) << (tcu_pkg::FRAC_W - 1);
        sat_nxt  = (whole > tcu_pkg::WHOLE_LIMIT);
        base_nxt = (whole << tcu_pkg::MS_SH_HI) - (whole << tcu_pkg::MS_SH_MID);
        frac_nxt = '0;
        cnt_nxt  = CNT_W'(tcu_pkg::FRAC_W - 1);
        state_nxt = tcu_pkg::ST_FRAC;
      end
      tcu_pkg::ST_FRAC: begin
        if (frac_ge) begin
          fr_nxt = fr_r - {1'b0, dvs_r};
        end
        frac_nxt = {frac_r[tcu_pkg::FRAC_W-2:0], frac_ge};
        dvs_nxt  = dvs_r >> 1;
        // finish whole * 1000, exact modulo 2^64 when not saturated
        if (cnt_r == CNT_W'(tcu_pkg::FRAC_W - 1)) begin
          base_nxt = base_r - (whole << tcu_pkg::MS_SH_LO);
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = tcu_pkg::ST_SUM;
        end
      end
      tcu_pkg::ST_SUM: begin
        // wait here while an unread result still occupies the output
        if (!out_vld_r || out_ch.ready) begin
          out_ms_nxt  = sum_sat ? '1 : ms_sum[tcu_pkg::MS_W-1:0];
          out_sat_nxt = sum_sat;
          out_vld_nxt = 1'b1;
          state_nxt   = tcu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tcu_pkg::ST_IDLE;
      cnt_r     <= '0;
      rate_r    <= tcu_pkg::RATE_RESET;
      wrap_r    <= '0;
      last_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rate_r    <= rate_nxt;
      wrap_r    <= wrap_nxt;
      last_r    <= last_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_rate_r <= div_rate_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    fr_r       <= fr_nxt;
    dvs_r      <= dvs_nxt;
    frac_r     <= frac_nxt;
    base_r     <= base_nxt;
    sat_r      <= sat_nxt;
    out_ms_r   <= out_ms_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  // a clamped result always reads all ones
  a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |-> out_ch.uptime_ms == '1)
    else $error("saturated result is not all ones");

  // accepted sample starts the division on the next cycle
  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == tcu_pkg::ST_DIV)
    else $error("division did not start after accept");

  // the running remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tcu_pkg::ST_DIV || state_r == tcu_pkg::ST_PREP |-> rem_r < div_rate_r)
    else $error("division remainder out of range");

  // the fractional milliseconds never reach a full second
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tcu_pkg::ST_SUM |-> frac_r < tcu_pkg::MS_PER_SEC)
    else $error("fraction out of range");

endmodule
